/* rtl/core/crks_pkg.sv */
// Package with shared types and constants of the Catmull-Rom keyframe sampler.
package crks_pkg;

  localparam int LANES      = 4;
  localparam int VALUE_W    = 32;
  localparam int N_W        = 7;
  localparam int MAX_N      = 64;
  localparam int D_W        = 6;
  localparam int H_W        = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CS_B,
    CS_A,
    CS_P1
  } coef_sel_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    logic      div_step;
    logic      h_init;
    logic      mul;
    logic      add;
    coef_sel_t coef_sel;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_sample;
    logic out_free;
    logic n_zero;
  } status_t;

endpackage

/* rtl/core/crks_ctrl.sv */
// Controller state machine that sequences load, divide, Horner steps and output.
module crks_ctrl
  import crks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_first,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] frames_seen;
  logic [1:0] frames_eff;
  logic       emit;
  logic [1:0] step;
  logic       accept;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign frames_eff = in_first ? 2'd0 : frames_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frames_seen <= 2'd0;
      emit        <= 1'b0;
      step        <= 2'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        emit        <= (frames_eff == 2'd3) && !status.n_zero;
        frames_seen <= (frames_eff == 2'd3) ? 2'd3 : frames_eff + 2'd1;
      end
      if (state == ST_LOAD || state == ST_OUT) begin
        step <= 2'd0;
      end else if (state == ST_ADD) begin
        step <= step + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_LOAD;
      ST_LOAD: state_next = emit ? ST_DIV : ST_IDLE;
      ST_DIV:  if (status.div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = (step == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (status.out_free) state_next = status.last_sample ? ST_IDLE : ST_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.coef_sel = CS_B;
    cmd.accept   = accept;
    unique case (state)
      ST_IDLE: ;
      ST_LOAD: begin
        cmd.load   = 1'b1;
        cmd.h_init = 1'b1;
      end
      ST_DIV:  cmd.div_step = !status.div_done;
      ST_MUL:  cmd.mul = 1'b1;
      ST_ADD: begin
        cmd.add = 1'b1;
        unique case (step)
          2'd0:    cmd.coef_sel = CS_B;
          2'd1:    cmd.coef_sel = CS_A;
          default: cmd.coef_sel = CS_P1;
        endcase
      end
      ST_OUT: begin
        cmd.out_load = status.out_free;
        cmd.h_init   = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/crks_datapath.sv */
// Datapath: keyframe window, coefficients, parameter stepping, Horner lanes, output register.
module crks_datapath
  import crks_pkg::*;
#(
  parameter int CHANNELS  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [LANES*VALUE_W-1:0] in_values,
  input  logic                     cfg_valid,
  input  logic [N_W-1:0]           cfg_data,
  output logic [LANES*VALUE_W-1:0] out_values,
  output logic                     out_last,
  output logic                     out_valid,
  input  logic                     out_ready
);

  localparam int U_W   = FRAC_BITS + 1;
  localparam int P_W   = H_W + U_W + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [H_W-1:0] SMAX = H_W'(2147483647);
  localparam logic signed [H_W-1:0] SMIN = -SMAX - H_W'(1);

  logic [N_W-1:0]   n_reg;
  logic [N_W-1:0]   n_eff;
  logic [D_W-1:0]   d;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     rem_sh;
  logic [U_W-1:0]   quo;
  logic [CNT_W-1:0] dcnt;
  logic [U_W-1:0]   uq;
  logic [D_W-1:0]   ur;
  logic [D_W:0]     ur_sum;
  logic [N_W-1:0]   j;

  assign n_eff  = (n_reg > N_W'(MAX_N)) ? N_W'(MAX_N) : n_reg;
  assign rem_sh = {rem, (dcnt == '0)};
  assign ur_sum = {1'b0, ur} + {1'b0, rem};

  assign status.div_done    = (dcnt == CNT_W'(FRAC_BITS + 1));
  assign status.last_sample = (j + N_W'(1) == n_eff);
  assign status.out_free    = !out_valid || out_ready;
  assign status.n_zero      = (n_reg == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= N_W'(8);
    end else if (cfg_valid) begin
      n_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d    <= D_W'(n_eff - N_W'(1));
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
      uq   <= '0;
      ur   <= D_W'((n_eff - N_W'(1)) >> 1);
      j    <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + CNT_W'(1);
      if (rem_sh >= {1'b0, d}) begin
        rem <= D_W'(rem_sh - {1'b0, d});
        quo <= {quo[U_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[D_W-1:0];
        quo <= {quo[U_W-2:0], 1'b0};
      end
    end else if (cmd.out_load) begin
      j <= j + N_W'(1);
      if (ur_sum >= {1'b0, d}) begin
        ur <= D_W'(ur_sum - {1'b0, d});
        uq <= uq + quo + U_W'(1);
      end else begin
        ur <= ur_sum[D_W-1:0];
        uq <= uq + quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_last <= status.last_sample;
  end

  for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_used
      logic signed [VALUE_W-1:0] nv;
      logic signed [VALUE_W-1:0] w0;
      logic signed [VALUE_W-1:0] w1;
      logic signed [VALUE_W-1:0] w2;
      logic signed [H_W-1:0]     p0;
      logic signed [H_W-1:0]     p1;
      logic signed [H_W-1:0]     p2;
      logic signed [H_W-1:0]     p3;
      logic signed [H_W-1:0]     ca;
      logic signed [H_W-1:0]     cb;
      logic signed [H_W-1:0]     cc;
      logic signed [H_W-1:0]     cp;
      logic signed [H_W-1:0]     cc_next;
      logic signed [H_W-1:0]     h;
      logic signed [H_W-1:0]     coef;
      logic signed [H_W-1:0]     hr;
      logic signed [P_W-1:0]     prod;
      logic signed [P_W-1:0]     prod_r;
      logic signed [H_W-1:0]     sat;
      logic [VALUE_W-1:0]        lane_out;

      assign p0 = H_W'(w0);
      assign p1 = H_W'(w1);
      assign p2 = H_W'(w2);
      assign p3 = H_W'(nv);
      assign cc_next = -p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3;

      always_comb begin
        case (cmd.coef_sel)
          CS_B:    coef = cb;
          CS_A:    coef = ca;
          default: coef = cp;
        endcase
      end

      assign prod_r = (prod + HALF) >>> FRAC_BITS;
      assign hr     = (h + H_W'(1)) >>> 1;
      assign sat    = (hr > SMAX) ? SMAX : ((hr < SMIN) ? SMIN : hr);

      always_ff @(posedge clk) begin
        if (cmd.accept) nv <= in_values[ch*VALUE_W +: VALUE_W];
        if (cmd.load) begin
          w0 <= w1;
          w1 <= w2;
          w2 <= nv;
          ca <= p2 - p0;
          cb <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
          cc <= cc_next;
          cp <= p1 <<< 1;
        end
        if (cmd.load) begin
          h <= cc_next;
        end else if (cmd.h_init) begin
          h <= cc;
        end else if (cmd.add) begin
          h <= prod_r[H_W-1:0] + coef;
        end
        if (cmd.mul) prod <= P_W'(h) * $signed({1'b0, uq});
        if (cmd.out_load) lane_out <= sat[VALUE_W-1:0];
      end

      assign out_values[ch*VALUE_W +: VALUE_W] = lane_out;
    end else begin : g_unused
      assign out_values[ch*VALUE_W +: VALUE_W] = '0;
    end
  end

endmodule

/* rtl/core/catmull_rom_keyframe_sampler.sv */
// Top level of the uniform Catmull-Rom keyframe sampler.
// Keyframes enter on the s_axis channel: tdata carries four signed Q16.16
// channel values, tuser the first flag that starts a new sequence. Once three
// earlier keyframes of the sequence are held, each keyframe yields N samples
// on m_axis between the middle two keyframes, tlast marking the final one.
// N is written on the cfg channel (reset value 8, values above 64 act as 64,
// zero emits nothing). Channels at or above CHANNELS read as zero.
// Each keyframe is first loaded into the window; a keyframe that yields
// samples then passes through the serial divider that forms the parameter
// step, followed per sample by three multiply and add passes of the Horner
// lanes and one output load. No new keyframe is taken until the segment
// is done. Results sit in an output register; while the receiver stalls the
// sequencer holds the next sample until the register is free.
// Reset clears the window count, the control state and sets N to 8.
module catmull_rom_keyframe_sampler
  import crks_pkg::*;
#(
  parameter int CHANNELS  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [LANES*VALUE_W-1:0] s_axis_tdata,  // value_0, value_1, value_2, value_3
  input  logic                     s_axis_tuser,  // first
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [LANES*VALUE_W-1:0] m_axis_tdata,  // sample_0, sample_1, sample_2, sample_3
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [N_W-1:0]           cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  crks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_first (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  crks_datapath #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_values  (s_axis_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_values (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready)
  );

endmodule

/* tb/sv/spline_checker.sv */
// Checker that predicts the spline samples of the keyframe sampler and compares them.
module spline_checker
  import crks_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [LANES*VALUE_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tuser,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [LANES*VALUE_W-1:0] m_axis_tdata,
  input  logic                     m_axis_tlast,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [N_W-1:0]           cfg_data,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic [LANES*VALUE_W-1:0] samples;
    logic                     last;
  } sample_t;

  localparam int FB = 16;

  sample_t              expected_samples[$];
  logic [N_W-1:0]       seg_len;
  logic [VALUE_W-1:0]   keys[3][LANES];
  int                   held;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [VALUE_W-1:0] horner(longint p0, longint p1, longint p2,
                                                 longint p3, longint u);
    longint a, b, c, h;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    h = c;
    h = rnd_shift(h * u, FB) + b;
    h = rnd_shift(h * u, FB) + a;
    h = rnd_shift(h * u, FB) + 2 * p1;
    h = rnd_shift(h, 1);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[VALUE_W-1:0];
  endfunction

  task automatic predict_segment(logic first, logic [LANES*VALUE_W-1:0] data);
    int      n;
    longint  u;
    sample_t s;
    if (first) held = 0;
    n = (seg_len > MAX_N) ? MAX_N : seg_len;
    if (held >= 3) begin
      for (int j = 0; j < n; j++) begin
        u = 0;
        if (n > 1) u = (longint'(j) * 65536 + (n - 1) / 2) / (n - 1);
        for (int ch = 0; ch < LANES; ch++) begin
          s.samples[ch*VALUE_W +: VALUE_W] = horner(
            longint'($signed(keys[0][ch])), longint'($signed(keys[1][ch])),
            longint'($signed(keys[2][ch])),
            longint'($signed(data[ch*VALUE_W +: VALUE_W])), u);
        end
        s.last = (j == n - 1);
        expected_samples.insert(expected_samples.size(), s);
      end
    end
    for (int ch = 0; ch < LANES; ch++) begin
      keys[0][ch] = keys[1][ch];
      keys[1][ch] = keys[2][ch];
      keys[2][ch] = data[ch*VALUE_W +: VALUE_W];
    end
    if (held < 3) held++;
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      seg_len = 8;
      held = 0;
      errors = 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) seg_len = cfg_data;
      if (s_axis_tvalid && s_axis_tready) predict_segment(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample %h last %b", $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          for (int ch = 0; ch < LANES; ch++)
            if (m_axis_tdata[ch*VALUE_W +: VALUE_W] !== e.samples[ch*VALUE_W +: VALUE_W]) begin
              $display("%0t: sample_%0d expected %h actual %h", $time, ch,
                       e.samples[ch*VALUE_W +: VALUE_W], m_axis_tdata[ch*VALUE_W +: VALUE_W]);
              errors++;
            end
          if (m_axis_tlast !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the testbench: clock, reset, keyframe stimulus and the verdict.
module testbench
  import crks_pkg::*;
();

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     s_axis_tvalid = 0;
  logic                     s_axis_tready;
  logic [LANES*VALUE_W-1:0] s_axis_tdata = '0;
  logic                     s_axis_tuser = 0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 0;
  logic [LANES*VALUE_W-1:0] m_axis_tdata;
  logic                     m_axis_tlast;
  logic                     cfg_valid = 0;
  logic                     cfg_ready;
  logic [N_W-1:0]           cfg_data = '0;
  int                       errors;
  int                       pending;
  int                       send_idle = 8;
  int                       recv_idle = 70;
  longint                   cycles = 0;

  always #5 clk = ~clk;

  catmull_rom_keyframe_sampler dut (.*);

  spline_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [VALUE_W-1:0] pick_value(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(65536 * 8) - 65536 * 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_key(logic first, logic [LANES*VALUE_W-1:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_len(logic [N_W-1:0] n);
    drain();
    cfg_valid <= 1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_random(int count, int mode);
    logic [LANES*VALUE_W-1:0] d;
    for (int i = 0; i < count; i++) begin
      for (int ch = 0; ch < LANES; ch++) d[ch*VALUE_W +: VALUE_W] = pick_value(mode);
      send_key(i == 0 || $urandom_range(19) == 0, d);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed part: default length, extremes, restart with a full window.
    send_key(1, {4{32'h7FFF_FFFF}});
    send_key(0, {4{32'h8000_0000}});
    send_key(0, {4{32'h7FFF_FFFF}});
    send_key(0, {4{32'h8000_0000}});
    send_key(0, {32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h5555_AAAA});
    send_key(1, {4{32'h1234_5678}});
    send_random(5, 3);
    write_len(1);
    send_random(5, 2);
    write_len(0);
    send_random(5, 3);
    write_len(127);
    send_random(5, 2);
    write_len(64);
    send_random(5, 1);
    write_len(2);
    send_random(40, 2);
    drain();
    write_len(5);
    send_random(35, 3);
    send_idle = 70;
    recv_idle = 8;
    write_len(3);
    send_random(40, 2);
    write_len(17);
    send_random(30, 3);
    send_idle = 0;
    recv_idle = 0;
    write_len(9);
    send_random(40, 2);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
